/* hdl/vau_pkg.sv */
// shared types and codes for the three-component vector arithmetic unit
// no dependencies; imported by every module of the block
package vau_pkg;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_SCALE = 4'd2;
    localparam logic [3:0] CMD_DIV   = 4'd3;
    localparam logic [3:0] CMD_DOT   = 4'd4;
    localparam logic [3:0] CMD_SQMAG = 4'd5;
    localparam logic [3:0] CMD_MAG   = 4'd6;
    localparam logic [3:0] CMD_NORM  = 4'd7;
    localparam logic [3:0] CMD_CROSS = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_ZNORM = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // per-item context carried alongside the arithmetic
    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] scale;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_s;
        logic               sat;
        logic [1:0]         status;
    } vau_ctx_t;

    // square root cell data: radicand left to consume, partial remainder and root
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } vau_sq_t;

    // one divider lane: remainder, numerator bits left, quotient so far
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } vau_lane_t;

endpackage

/* hdl/vau_sqrt_cell.sv */
// one cell of the square root chain: resolves one root bit per item
// depends on vau_pkg
module vau_sqrt_cell
    import vau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     valid_i,
    input  vau_ctx_t ctx_i,
    input  vau_sq_t  sq_i,
    output logic     valid_o,
    output vau_ctx_t ctx_o,
    output vau_sq_t  sq_o
);

    logic     valid_reg;
    vau_ctx_t ctx_reg;
    vau_sq_t  sq_reg, sq_next;
    logic [35:0] rem_sh, trial;

    always_comb begin
        rem_sh = {sq_i.rem, sq_i.rad[63:62]};
        trial  = {2'b00, sq_i.root, 2'b01};
        sq_next.rad = {sq_i.rad[61:0], 2'b00};
        if (rem_sh >= trial) begin
            sq_next.rem  = 34'(rem_sh - trial);
            sq_next.root = {sq_i.root[30:0], 1'b1};
        end else begin
            sq_next.rem  = rem_sh[33:0];
            sq_next.root = {sq_i.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg <= ctx_i;
            sq_reg  <= sq_next;
        end
    end

    assign valid_o = valid_reg;
    assign ctx_o   = ctx_reg;
    assign sq_o    = sq_reg;

endmodule

/* hdl/vau_div_cell.sv */
// one cell of the divider chain: one quotient bit for each of three lanes
// depends on vau_pkg
module vau_div_cell
    import vau_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            valid_i,
    input  vau_ctx_t        ctx_i,
    input  logic [31:0]     dsor_i,
    input  vau_lane_t [2:0] lane_i,
    output logic            valid_o,
    output vau_ctx_t        ctx_o,
    output logic [31:0]     dsor_o,
    output vau_lane_t [2:0] lane_o
);

    logic            valid_reg;
    vau_ctx_t        ctx_reg;
    logic [31:0]     dsor_reg;
    vau_lane_t [2:0] lane_reg, lane_next;
    logic [32:0]     rem_sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rem_sh[i] = {lane_i[i].rem, lane_i[i].num[31]};
            lane_next[i]     = lane_i[i];
            lane_next[i].num = {lane_i[i].num[30:0], 1'b0};
            if (rem_sh[i] >= {1'b0, dsor_i}) begin
                lane_next[i].rem = 32'(rem_sh[i] - {1'b0, dsor_i});
                lane_next[i].quo = {lane_i[i].quo[30:0], 1'b1};
            end else begin
                lane_next[i].rem = rem_sh[i][31:0];
                lane_next[i].quo = {lane_i[i].quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg  <= ctx_i;
            dsor_reg <= dsor_i;
            lane_reg <= lane_next;
        end
    end

    assign valid_o = valid_reg;
    assign ctx_o   = ctx_reg;
    assign dsor_o  = dsor_reg;
    assign lane_o  = lane_reg;

endmodule

/* hdl/vec3_arith_unit.sv */
// top level of the three-component vector arithmetic unit, signed fixed point
// depends on vau_pkg, vau_sqrt_cell and vau_div_cell
//
// One command and two 3-component vectors plus a scalar enter per transaction
// and exactly one result leaves per transaction, in order. The block takes one
// transaction every cycle unless the output stalls; the pipeline is one multiply
// stage, one combine stage, a chain of 32 square root cells (one root bit
// each), one divider setup stage, a chain of 32 divider cells (one quotient bit
// per cell for all three components) and the output register. Every item runs
// the full chain whatever its command. The whole pipeline holds while a result
// waits in the output register, so s_tready follows m_tready combinationally.
// zero_limit is written on its own channel (always ready) and should only be
// changed while no transaction is in flight.
module vec3_arith_unit
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // command input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scale
    input  logic [3:0]   s_tuser,   // cmd
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // r_x, r_y, r_z, r_scalar
    output logic [1:0]   m_tuser,   // status
    // zero_limit register
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data
);

    localparam int NUM_W  = 32 + FRAC_BITS;  // magnitude of a component shifted up
    localparam int STAGES = 32;              // cells in each chain

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } sat_t;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t res;
        res.sat = 1'b0;
        res.val = v[31:0];
        if (v > 66'sd2147483647) begin
            res.sat = 1'b1;
            res.val = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            res.sat = 1'b1;
            res.val = 32'sh80000000;
        end
        return res;
    endfunction

    // quotient magnitude and sign back to a saturated signed value
    function automatic sat_t lane_result(input vau_lane_t l);
        sat_t res;
        res.sat = 1'b0;
        res.val = l.quo;
        if (l.ovf) begin
            res.sat = 1'b1;
            res.val = l.neg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (l.neg) begin
            if (l.quo > 32'h80000000) begin
                res.sat = 1'b1;
                res.val = 32'sh80000000;
            end else begin
                res.val = 32'(32'h0 - l.quo);
            end
        end else if (l.quo[31]) begin
            res.sat = 1'b1;
            res.val = 32'sh7fffffff;
        end
        return res;
    endfunction

    // global advance: every stage moves when the output register can take data
    logic adv;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    logic [16:0] zero_limit_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_limit_reg <= 17'd1;
        end else if (cfg_valid) begin
            zero_limit_reg <= cfg_data;
        end
    end

    // ---------------- multiply stage ----------------
    logic signed [31:0] in_a [3];
    logic signed [31:0] in_b [3];
    logic signed [31:0] in_s;
    assign in_a[0] = s_tdata[31:0];
    assign in_a[1] = s_tdata[63:32];
    assign in_a[2] = s_tdata[95:64];
    assign in_b[0] = s_tdata[127:96];
    assign in_b[1] = s_tdata[159:128];
    assign in_b[2] = s_tdata[191:160];
    assign in_s    = s_tdata[223:192];

    logic signed [31:0] opa [6];
    logic signed [31:0] opb [6];
    logic signed [63:0] prod [6];
    logic signed [63:0] p_next [6];
    logic signed [63:0] p_reg [6];
    logic               mul_valid_reg;
    vau_ctx_t           mul_ctx_reg, mul_ctx_next;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            opa[i] = '0;
            opb[i] = '0;
        end
        case (s_tuser)
            CMD_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    opa[i] = in_a[i];
                    opb[i] = in_s;
                end
            end
            CMD_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    opa[i] = in_a[i];
                    opb[i] = in_b[i];
                end
            end
            CMD_SQMAG, CMD_MAG, CMD_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    opa[i] = in_a[i];
                    opb[i] = in_a[i];
                end
            end
            CMD_CROSS: begin
                // pairs (0,3), (1,4), (2,5) form the three differences
                opa[0] = in_a[1]; opb[0] = in_b[2];
                opa[3] = in_a[2]; opb[3] = in_b[1];
                opa[1] = in_a[2]; opb[1] = in_b[0];
                opa[4] = in_a[0]; opb[4] = in_b[2];
                opa[2] = in_a[0]; opb[2] = in_b[1];
                opa[5] = in_a[1]; opb[5] = in_b[0];
            end
            default: ;
        endcase
        for (int i = 0; i < 6; i++) begin
            prod[i]   = opa[i] * opb[i];
            p_next[i] = prod[i];
        end
        // add and subtract ride in the product slots
        if (s_tuser == CMD_ADD) begin
            for (int i = 0; i < 3; i++) begin
                p_next[i] = 64'(in_a[i]) + 64'(in_b[i]);
            end
        end else if (s_tuser == CMD_SUB) begin
            for (int i = 0; i < 3; i++) begin
                p_next[i] = 64'(in_a[i]) - 64'(in_b[i]);
            end
        end
        mul_ctx_next        = '0;
        mul_ctx_next.cmd    = s_tuser;
        mul_ctx_next.a_x    = in_a[0];
        mul_ctx_next.a_y    = in_a[1];
        mul_ctx_next.a_z    = in_a[2];
        mul_ctx_next.scale  = in_s;
        mul_ctx_next.status = ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_ctx_reg <= mul_ctx_next;
            for (int i = 0; i < 6; i++) begin
                p_reg[i] <= p_next[i];
            end
        end
    end

    // ---------------- combine stage ----------------
    logic signed [65:0] pe [6];
    logic signed [65:0] sum3;
    logic signed [65:0] diff [3];
    sat_t               cs [3];
    sat_t               css;
    vau_ctx_t           c_ctx_next, c_ctx_reg;
    logic [63:0]        rad_next, c_rad_reg;
    logic               c_valid_reg;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pe[i] = 66'(p_reg[i]);
        end
        sum3 = pe[0] + pe[1] + pe[2];
        for (int i = 0; i < 3; i++) begin
            diff[i] = pe[i] - pe[i + 3];
            cs[i]   = '0;
        end
        css        = '0;
        c_ctx_next = mul_ctx_reg;
        // squares are never negative, the sum of three fits 64 bits unsigned
        rad_next   = 64'(p_reg[0]) + 64'(p_reg[1]) + 64'(p_reg[2]);
        case (mul_ctx_reg.cmd)
            CMD_ADD, CMD_SUB: begin
                for (int i = 0; i < 3; i++) cs[i] = sat32(pe[i]);
            end
            CMD_SCALE: begin
                for (int i = 0; i < 3; i++) cs[i] = sat32(pe[i] >>> FRAC_BITS);
            end
            CMD_DOT, CMD_SQMAG: begin
                css = sat32(sum3 >>> FRAC_BITS);
            end
            CMD_CROSS: begin
                for (int i = 0; i < 3; i++) cs[i] = sat32(diff[i] >>> FRAC_BITS);
            end
            default: ;
        endcase
        c_ctx_next.r_x = cs[0].val;
        c_ctx_next.r_y = cs[1].val;
        c_ctx_next.r_z = cs[2].val;
        c_ctx_next.r_s = css.val;
        c_ctx_next.sat = cs[0].sat | cs[1].sat | cs[2].sat | css.sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_ctx_reg <= c_ctx_next;
            c_rad_reg <= rad_next;
        end
    end

    // ---------------- square root chain ----------------
    logic     sq_valid [STAGES + 1];
    vau_ctx_t sq_ctx   [STAGES + 1];
    vau_sq_t  sq_data  [STAGES + 1];

    assign sq_valid[0]     = c_valid_reg;
    assign sq_ctx[0]       = c_ctx_reg;
    assign sq_data[0].rad  = c_rad_reg;
    assign sq_data[0].rem  = '0;
    assign sq_data[0].root = '0;

    for (genvar k = 0; k < STAGES; k++) begin : g_sqrt
        vau_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .valid_i (sq_valid[k]),
            .ctx_i   (sq_ctx[k]),
            .sq_i    (sq_data[k]),
            .valid_o (sq_valid[k + 1]),
            .ctx_o   (sq_ctx[k + 1]),
            .sq_o    (sq_data[k + 1])
        );
    end

    // ---------------- divider setup ----------------
    logic [31:0]          root;
    logic signed [31:0]   sa [3];
    logic [31:0]          ua [3];
    logic [NUM_W-1:0]     un [3];
    logic [FRAC_BITS-1:0] hi [3];
    logic [31:0]          dsor_next, d_dsor_reg;
    vau_lane_t [2:0]      lane_next, d_lane_reg;
    vau_ctx_t             d_ctx_next, d_ctx_reg;
    logic                 d_valid_reg;
    logic                 s_neg;

    always_comb begin
        root       = sq_data[STAGES].root;
        d_ctx_next = sq_ctx[STAGES];
        sa[0] = d_ctx_next.a_x;
        sa[1] = d_ctx_next.a_y;
        sa[2] = d_ctx_next.a_z;
        s_neg = 1'b0;
        if (d_ctx_next.cmd == CMD_DIV) begin
            s_neg     = d_ctx_next.scale[31];
            dsor_next = s_neg ? 32'(32'h0 - d_ctx_next.scale) : d_ctx_next.scale;
            if (d_ctx_next.scale == 32'sd0) d_ctx_next.status = ST_DIV0;
        end else begin
            dsor_next = root;
        end
        if (d_ctx_next.cmd == CMD_MAG) begin
            d_ctx_next.sat = root[31];
            d_ctx_next.r_s = root[31] ? 32'sh7fffffff : root;
        end
        if (d_ctx_next.cmd == CMD_NORM && root <= 32'(zero_limit_reg)) begin
            d_ctx_next.status = ST_ZNORM;
        end
        for (int i = 0; i < 3; i++) begin
            ua[i] = sa[i][31] ? 32'(32'h0 - sa[i]) : sa[i];
            un[i] = {ua[i], {FRAC_BITS{1'b0}}};
            hi[i] = un[i][NUM_W-1:32];
            // quotient at or above 2^32 is settled here, the chain makes 32 bits
            lane_next[i].ovf = 32'(hi[i]) >= dsor_next;
            lane_next[i].rem = 32'(hi[i]);
            lane_next[i].num = un[i][31:0];
            lane_next[i].quo = '0;
            lane_next[i].neg = sa[i][31] ^ s_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= sq_valid[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_ctx_reg  <= d_ctx_next;
            d_dsor_reg <= dsor_next;
            d_lane_reg <= lane_next;
        end
    end

    // ---------------- divider chain ----------------
    logic            dv_valid [STAGES + 1];
    vau_ctx_t        dv_ctx   [STAGES + 1];
    logic [31:0]     dv_dsor  [STAGES + 1];
    vau_lane_t [2:0] dv_lane  [STAGES + 1];

    assign dv_valid[0] = d_valid_reg;
    assign dv_ctx[0]   = d_ctx_reg;
    assign dv_dsor[0]  = d_dsor_reg;
    assign dv_lane[0]  = d_lane_reg;

    for (genvar k = 0; k < STAGES; k++) begin : g_div
        vau_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .valid_i (dv_valid[k]),
            .ctx_i   (dv_ctx[k]),
            .dsor_i  (dv_dsor[k]),
            .lane_i  (dv_lane[k]),
            .valid_o (dv_valid[k + 1]),
            .ctx_o   (dv_ctx[k + 1]),
            .dsor_o  (dv_dsor[k + 1]),
            .lane_o  (dv_lane[k + 1])
        );
    end

    // ---------------- output register ----------------
    vau_ctx_t           f_ctx;
    sat_t               fl [3];
    logic signed [31:0] rx, ry, rz;
    logic               f_sat;
    logic [127:0]       tdata_next, m_tdata_reg;
    logic [1:0]         tuser_next, m_tuser_reg;
    logic               m_valid_reg;

    always_comb begin
        f_ctx = dv_ctx[STAGES];
        for (int i = 0; i < 3; i++) fl[i] = lane_result(dv_lane[STAGES][i]);
        rx    = f_ctx.r_x;
        ry    = f_ctx.r_y;
        rz    = f_ctx.r_z;
        f_sat = f_ctx.sat;
        if ((f_ctx.cmd == CMD_DIV || f_ctx.cmd == CMD_NORM) && f_ctx.status == ST_OK) begin
            rx    = fl[0].val;
            ry    = fl[1].val;
            rz    = fl[2].val;
            f_sat = fl[0].sat | fl[1].sat | fl[2].sat;
        end
        tdata_next = {f_ctx.r_s, rz, ry, rx};
        tuser_next = (f_ctx.status == ST_OK && f_sat) ? ST_SAT : f_ctx.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* hdl/vau_checker.sv */
// port-level checks for the vector arithmetic unit, bound to the top level
// depends on vau_pkg and vec3_arith_unit
module vau_checker
    import vau_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // a held result stays put
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input only backs off while a result is waiting
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // divide by zero and zero-length normalise give all-zero values
    a_zero_vals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_DIV0 || m_tuser == ST_ZNORM) |-> m_tdata == '0)
        else $error("nonzero values with zero-divisor status");

endmodule

bind vec3_arith_unit vau_checker u_vau_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench for vec3_arith_unit: drives random and directed vector commands and
// checks every result against a fixed-point predictor; depends on vau_pkg and the rtl
module testbench;
    import vau_pkg::*;

    localparam int FRAC      = 16;
    localparam int LATENCY   = 68;
    localparam int IDLE_MAX  = 3000;   // cycles with no transaction before giving up

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] ax, ay, az, bx, by, bz, sc;
    } vec_cmd_t;

    typedef struct packed {
        logic signed [31:0] rx, ry, rz, rs;
        logic [1:0]         status;
    } vec_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;   // a_x, a_y, a_z, b_x, b_y, b_z, scale
    logic [3:0]   s_tuser = '0;   // cmd
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // r_x, r_y, r_z, r_scalar
    logic [1:0]   m_tuser;        // status
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [16:0]  cfg_data = '0;

    vec_cmd_t    cmd_queue[$];      // commands waiting for the driver
    vec_res_t    predicted_res[$];  // results owed by the block, oldest first
    vec_cmd_t    cur_cmd;           // command currently on s_tdata
    logic [16:0] zero_limit_q = 17'd1;
    int          errors = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          idle_cycles = 0;
    int unsigned cyc = 0;

    vec3_arith_unit #(.FRAC_BITS(FRAC)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // clip to the 32-bit range and flag it
    function automatic logic signed [31:0] clip32(input logic signed [127:0] v,
                                                  inout logic flag);
        if (v > 128'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // floor square root, one result bit per step
    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] rem, res, bitv;
        rem = v;
        res = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // expected result of one command; 128-bit intermediates keep every product exact
    function automatic vec_res_t vec3_predict(input vec_cmd_t c, input logic [16:0] zl);
        logic signed [127:0] a[3], b[3], s, t;
        logic signed [31:0]  rv[3];
        logic signed [31:0]  rs;
        logic [63:0]         mag;
        logic [1:0]          st;
        logic                flag;
        vec_res_t            r;
        a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
        b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
        s = c.sc;
        rv[0] = '0; rv[1] = '0; rv[2] = '0;
        rs = '0;
        st = ST_OK;
        flag = 1'b0;
        case (c.cmd) inside
            CMD_ADD: for (int i = 0; i < 3; i++) rv[i] = clip32(a[i] + b[i], flag);
            CMD_SUB: for (int i = 0; i < 3; i++) rv[i] = clip32(a[i] - b[i], flag);
            CMD_SCALE: for (int i = 0; i < 3; i++) rv[i] = clip32((a[i] * s) >>> FRAC, flag);
            CMD_DIV: begin
                if (s == 0) st = ST_DIV0;
                else for (int i = 0; i < 3; i++) rv[i] = clip32((a[i] <<< FRAC) / s, flag);
            end
            CMD_DOT: rs = clip32((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> FRAC, flag);
            CMD_SQMAG: rs = clip32((a[0]*a[0] + a[1]*a[1] + a[2]*a[2]) >>> FRAC, flag);
            CMD_MAG, CMD_NORM: begin
                t = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
                mag = root64(t[63:0]);
                t = $signed({64'd0, mag});
                if (c.cmd == CMD_MAG) rs = clip32(t, flag);
                else if (mag <= {47'd0, zl}) st = ST_ZNORM;
                else for (int i = 0; i < 3; i++) rv[i] = clip32((a[i] <<< FRAC) / t, flag);
            end
            CMD_CROSS: begin
                rv[0] = clip32((a[1]*b[2] - a[2]*b[1]) >>> FRAC, flag);
                rv[1] = clip32((a[2]*b[0] - a[0]*b[2]) >>> FRAC, flag);
                rv[2] = clip32((a[0]*b[1] - a[1]*b[0]) >>> FRAC, flag);
            end
            default: ;   // unknown commands give zeros and ok
        endcase
        if (flag && st == ST_OK) st = ST_SAT;
        r.rx = rv[0]; r.ry = rv[1]; r.rz = rv[2]; r.rs = rs; r.status = st;
        return r;
    endfunction

    // operand with a spread of magnitudes: extremes, small, medium and full range
    function automatic logic signed [31:0] vec_word();
        logic signed [31:0] w;
        case ($urandom_range(9))
            0: w = 32'sh80000000;
            1: w = 32'sh7fffffff;
            2: w = $urandom_range(2) == 0 ? 32'sd0 : 32'sd65536;
            3, 4: w = $signed($urandom_range(262143)) - 32'sd131072;
            5, 6: w = $signed($urandom_range(33554431)) - 32'sd16777216;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic vec_cmd_t vec_rand_cmd();
        vec_cmd_t c;
        c.cmd = $urandom_range(19) == 0 ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        c.ax = vec_word(); c.ay = vec_word(); c.az = vec_word();
        c.bx = vec_word(); c.by = vec_word(); c.bz = vec_word();
        c.sc = vec_word();
        if (c.cmd == CMD_DIV && $urandom_range(7) == 0) c.sc = '0;
        // short vectors to land near the zero limit when normalising
        if (c.cmd == CMD_NORM && $urandom_range(2) == 0) begin
            c.ax = $signed($urandom_range(131072)) - 32'sd65536;
            c.ay = $urandom_range(1) ? 32'sd0 : $signed($urandom_range(64)) - 32'sd32;
            c.az = $urandom_range(1) ? 32'sd0 : $signed($urandom_range(64)) - 32'sd32;
        end
        return c;
    endfunction

    function automatic vec_cmd_t mk(input logic [3:0] op, input logic signed [31:0] x,
                                    input logic signed [31:0] y, input logic signed [31:0] s);
        vec_cmd_t c;
        c.cmd = op;
        c.ax = x; c.ay = x; c.az = y;
        c.bx = y; c.by = x; c.bz = y;
        c.sc = s;
        return c;
    endfunction

    // write the zero limit while nothing is in flight
    task automatic write_zero_limit(input logic [16:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        zero_limit_q = v;
    endtask

    // wait until every command went in and every result came out, then let the pipe settle
    task automatic drain();
        while (cmd_queue.size() != 0 || s_tvalid || predicted_res.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // driver: bursts of commands with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predicted_res.push_back(vec3_predict(cur_cmd, zero_limit_q));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    cur_cmd  <= cmd_queue[0];
                    s_tdata  <= {cmd_queue[0].sc, cmd_queue[0].bz, cmd_queue[0].by,
                                 cmd_queue[0].bx, cmd_queue[0].az, cmd_queue[0].ay,
                                 cmd_queue[0].ax};
                    s_tuser  <= cmd_queue[0].cmd;
                    s_tvalid <= 1'b1;
                    void'(cmd_queue.pop_front());
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(40, 1);
                        gap_left = $urandom_range(3) == 0 ? 0 : $urandom_range(12, 1);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure: bits 9:8 of the cycle counter pick one of four stall patterns
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case (cyc[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(1));
                2'd2: m_tready <= $urandom_range(3) == 0;
                default: m_tready <= cyc[3:1] != 3'd0;
            endcase
        end
    end

    // monitor: every result transaction against the oldest prediction
    always @(posedge aclk) begin
        vec_res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_res.size() == 0) begin
                $error("result with nothing predicted");
                errors++;
            end else begin
                exp_r = predicted_res.pop_front();
                if (m_tdata[31:0] !== exp_r.rx) begin
                    $error("r_x expected %0d got %0d", exp_r.rx, $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tdata[63:32] !== exp_r.ry) begin
                    $error("r_y expected %0d got %0d", exp_r.ry, $signed(m_tdata[63:32]));
                    errors++;
                end
                if (m_tdata[95:64] !== exp_r.rz) begin
                    $error("r_z expected %0d got %0d", exp_r.rz, $signed(m_tdata[95:64]));
                    errors++;
                end
                if (m_tdata[127:96] !== exp_r.rs) begin
                    $error("r_scalar expected %0d got %0d", exp_r.rs,
                           $signed(m_tdata[127:96]));
                    errors++;
                end
                if (m_tuser !== exp_r.status) begin
                    $error("status expected %0d got %0d", exp_r.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        logic [16:0] limits[5];
        limits[0] = 17'd0;
        limits[1] = 17'd65536;
        limits[2] = 17'h1ffff;
        limits[3] = 17'($urandom_range(65536));
        limits[4] = 17'd1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed commands under the reset zero limit
        cmd_queue.push_back(mk(CMD_ADD, 32'sh7fffffff, 32'sh7fffffff, 0));
        cmd_queue.push_back(mk(CMD_ADD, 32'sh80000000, 32'sh80000000, 0));
        cmd_queue.push_back(mk(CMD_SUB, 32'sh80000000, 32'sh7fffffff, 0));
        cmd_queue.push_back(mk(CMD_SUB, 32'sd65536, -32'sd1, 0));
        cmd_queue.push_back(mk(CMD_SCALE, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
        cmd_queue.push_back(mk(CMD_SCALE, -32'sd3, 32'sd65536, 32'sd32768));
        cmd_queue.push_back(mk(CMD_DIV, 32'sd65536, -32'sd7, 32'sd0));
        cmd_queue.push_back(mk(CMD_DIV, 32'sh80000000, 32'sh7fffffff, 32'sd1));
        cmd_queue.push_back(mk(CMD_DIV, -32'sd100000, 32'sd3, -32'sd196608));
        cmd_queue.push_back(mk(CMD_DOT, 32'sh80000000, 32'sh80000000, 0));
        cmd_queue.push_back(mk(CMD_DOT, -32'sd3, 32'sd5, 0));
        cmd_queue.push_back(mk(CMD_SQMAG, 32'sh7fffffff, 32'sh80000000, 0));
        cmd_queue.push_back(mk(CMD_SQMAG, 32'sd1, 32'sd0, 0));
        cmd_queue.push_back(mk(CMD_MAG, 32'sh80000000, 32'sh80000000, 0));
        cmd_queue.push_back(mk(CMD_MAG, 32'sd65536, 32'sd0, 0));
        cmd_queue.push_back(mk(CMD_NORM, 32'sd0, 32'sd0, 0));
        cmd_queue.push_back(mk(CMD_NORM, 32'sd1, 32'sd0, 0));   // magnitude equal to limit
        cmd_queue.push_back(mk(CMD_NORM, 32'sd2, 32'sd0, 0));
        cmd_queue.push_back(mk(CMD_NORM, 32'sh80000000, 32'sh7fffffff, 0));
        cmd_queue.push_back(mk(CMD_CROSS, 32'sh7fffffff, 32'sh80000000, 0));
        cmd_queue.push_back(mk(CMD_CROSS, 32'sd65536, -32'sd131072, 0));
        cmd_queue.push_back(mk(4'd9, 32'sd5, 32'sd5, 32'sd5));
        cmd_queue.push_back(mk(4'd15, -32'sd1, -32'sd1, -32'sd1));
        drain();

        // random phases, each under its own zero limit
        foreach (limits[p]) begin
            write_zero_limit(limits[p]);
            if (p == 1) begin
                cmd_queue.push_back(mk(CMD_NORM, 32'sd65536, 32'sd0, 0));
                cmd_queue.push_back(mk(CMD_NORM, 32'sd65537, 32'sd0, 0));
            end
            repeat (376) cmd_queue.push_back(vec_rand_cmd());
            drain();
        end

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
hdl/vau_pkg.sv
hdl/vau_sqrt_cell.sv
hdl/vau_div_cell.sv
hdl/vec3_arith_unit.sv
hdl/vau_checker.sv
tb/testbench.sv
